### rtl/cmc_pkg.sv
// Shared types, codes and constants of the curtain motor controller.
`timescale 1ns / 1ps
package cmc_pkg;

  // Stall and rain debounce tick counts
  localparam logic [3:0] STALL_TICKS = 4'd15;
  localparam logic [3:0] RAIN_TICKS  = 4'd10;

  // Light hysteresis offsets above the threshold
  localparam logic [8:0] CLOSE_OFFSET = 9'd20;
  localparam logic [8:0] OPEN_OFFSET  = 9'd10;

  // Light scaling
  localparam logic [6:0] PCT_SCALE = 7'd100;

  // Command byte codes
  localparam logic [7:0] CMD_OPEN  = 8'd1;
  localparam logic [7:0] CMD_CLOSE = 8'd2;

  // Input item kinds
  typedef enum logic [2:0] {
    KIND_SPEED = 3'd0,
    KIND_RAIN  = 3'd1,
    KIND_LIGHT = 3'd2,
    KIND_CMD   = 3'd3,
    KIND_KEY   = 3'd4
  } in_kind_t;

  // Classified operation for the back end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SPEED,
    OP_RAIN,
    OP_LIGHT,
    OP_CMD,
    OP_KEY
  } op_kind_t;

  // Drive requests
  typedef enum logic [1:0] {
    DRV_STOP,
    DRV_OPEN,
    DRV_CLOSE
  } drv_t;

  // Position status
  typedef enum logic [2:0] {
    POS_STOPPED      = 3'd0,
    POS_OPENING      = 3'd1,
    POS_OPEN_PAUSED  = 3'd2,
    POS_FULLY_OPEN   = 3'd3,
    POS_CLOSING      = 3'd4,
    POS_CLOSE_PAUSED = 3'd5,
    POS_FULLY_CLOSED = 3'd6
  } pos_t;

  // Motor drive
  typedef enum logic [1:0] {
    MOT_OFF = 2'd0,
    MOT_FWD = 2'd1,
    MOT_REV = 2'd2
  } motor_t;

  // End-stop limit
  typedef enum logic [1:0] {
    LIM_NONE  = 2'd0,
    LIM_OPEN  = 2'd1,
    LIM_CLOSE = 2'd2
  } limit_t;

  // Register indexes
  localparam logic REG_SMART     = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // Configuration seen by the back end
  typedef struct packed {
    logic       smart_enable;
    logic [7:0] light_threshold;
  } cfg_t;

  // Queue entry
  typedef struct packed {
    op_kind_t   kind;
    logic       level;
    logic [6:0] pct;
    drv_t       drv;
  } op_t;

  // Result beat
  typedef struct packed {
    logic       rain_report;
    logic       status_report;
    logic [6:0] light_percent;
    logic       rain_alarm;
    limit_t     end_limit;
    motor_t     motor_drive;
    pos_t       position_status;
  } res_t;

endpackage

### rtl/cmc_front.sv
// Front end: classifies input beats and scales light samples to percent.
`timescale 1ns / 1ps
module cmc_front (
  input  logic [2:0]      kind,
  input  logic            speed_level,
  input  logic            rain_level,
  input  logic [7:0]      light_sample,
  input  logic [7:0]      command,
  output cmc_pkg::op_t    op
);
  import cmc_pkg::*;

  logic [14:0] prod;
  logic [14:0] quot_sum;

  // Scale sample*100/255 by reciprocal: x/255 = (x + (x>>8) + 1) >> 8
  assign prod     = 15'(light_sample) * 15'(PCT_SCALE);
  assign quot_sum = prod + (prod >> 8) + 15'd1;

  // Decode kind and command
  always_comb begin
    op.pct   = quot_sum[14:8];
    op.level = 1'b0;
    op.drv   = DRV_STOP;
    unique case (kind)
      KIND_SPEED: begin
        op.kind  = OP_SPEED;
        op.level = speed_level;
      end
      KIND_RAIN: begin
        op.kind  = OP_RAIN;
        op.level = rain_level;
      end
      KIND_LIGHT: op.kind = OP_LIGHT;
      KIND_CMD: begin
        op.kind = OP_CMD;
        if (command == CMD_OPEN) begin
          op.drv = DRV_OPEN;
        end else if (command == CMD_CLOSE) begin
          op.drv = DRV_CLOSE;
        end
      end
      KIND_KEY: op.kind = OP_KEY;
      default:  op.kind = OP_NONE;
    endcase
  end

endmodule

### rtl/cmc_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module cmc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cmc_pkg::op_t  push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cmc_pkg::op_t  head_data
);
  import cmc_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

### rtl/cmc_back.sv
// Back end: position, stall, rain and light state plus the result register.
`timescale 1ns / 1ps
module cmc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cmc_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  cmc_pkg::op_t  q_op,
  output logic          q_pop,
  output logic          res_valid,
  output cmc_pkg::res_t res,
  input  logic          res_ready
);
  import cmc_pkg::*;

  typedef struct packed {
    pos_t   pos;
    motor_t mot;
  } drive_res_t;

  pos_t       pos_r, pos_nxt;
  motor_t     mot_r, mot_nxt;
  limit_t     lim_r, lim_nxt;
  logic       spd_last_r, spd_last_nxt;
  logic       spd_seen_r, spd_seen_nxt;
  logic [3:0] spd_cnt_r, spd_cnt_nxt;
  logic       spd_done_r, spd_done_nxt;
  logic       rain_last_r, rain_last_nxt;
  logic       rain_seen_r, rain_seen_nxt;
  logic [3:0] rain_cnt_r, rain_cnt_nxt;
  logic       rain_done_r, rain_done_nxt;
  logic       rain_flag_r, rain_flag_nxt;
  logic [6:0] light_r, light_nxt;
  logic       srep_nxt, rrep_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       res_r, res_nxt;

  // Apply a drive request to position and motor
  function automatic drive_res_t drive_f(pos_t pos, motor_t mot, limit_t lim, drv_t req);
    drive_res_t r;
    r.pos = pos;
    r.mot = mot;
    unique case (req)
      DRV_OPEN: begin
        if (pos != POS_FULLY_OPEN && lim != LIM_OPEN) begin
          r.pos = POS_OPENING;
          r.mot = MOT_FWD;
        end
      end
      DRV_CLOSE: begin
        if (pos != POS_FULLY_CLOSED && lim != LIM_CLOSE) begin
          r.pos = POS_CLOSING;
          r.mot = MOT_REV;
        end
      end
      default: begin
        if (lim == LIM_OPEN) begin
          r.pos = POS_FULLY_OPEN;
        end else if (lim == LIM_CLOSE) begin
          r.pos = POS_FULLY_CLOSED;
        end else if (pos == POS_OPENING) begin
          r.pos = POS_OPEN_PAUSED;
        end else if (pos == POS_CLOSING) begin
          r.pos = POS_CLOSE_PAUSED;
        end
        r.mot = MOT_OFF;
      end
    endcase
    return r;
  endfunction

  // Take a queue entry when the result register is free or draining
  assign q_pop     = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // Next state of the controller
  always_comb begin
    drive_res_t dr;
    dr            = '{pos: pos_r, mot: mot_r};
    pos_nxt       = pos_r;
    mot_nxt       = mot_r;
    lim_nxt       = lim_r;
    spd_last_nxt  = spd_last_r;
    spd_seen_nxt  = spd_seen_r;
    spd_cnt_nxt   = spd_cnt_r;
    spd_done_nxt  = spd_done_r;
    rain_last_nxt = rain_last_r;
    rain_seen_nxt = rain_seen_r;
    rain_cnt_nxt  = rain_cnt_r;
    rain_done_nxt = rain_done_r;
    rain_flag_nxt = rain_flag_r;
    light_nxt     = light_r;
    srep_nxt      = 1'b0;
    rrep_nxt      = 1'b0;
    if (q_pop) begin
      unique case (q_op.kind)
        OP_SPEED: begin
          if (!spd_seen_r || spd_last_r != q_op.level) begin
            spd_last_nxt = q_op.level;
            spd_seen_nxt = 1'b1;
            spd_cnt_nxt  = 4'd0;
            spd_done_nxt = 1'b0;
            lim_nxt      = LIM_NONE;
          end else if (!spd_done_r) begin
            if (spd_cnt_r >= STALL_TICKS) begin
              if (pos_r == POS_OPENING) begin
                lim_nxt = LIM_OPEN;
                dr      = drive_f(pos_r, mot_r, LIM_OPEN, DRV_STOP);
                pos_nxt = dr.pos;
                mot_nxt = dr.mot;
              end else if (pos_r == POS_CLOSING) begin
                lim_nxt = LIM_CLOSE;
                dr      = drive_f(pos_r, mot_r, LIM_CLOSE, DRV_STOP);
                pos_nxt = dr.pos;
                mot_nxt = dr.mot;
              end
              srep_nxt     = 1'b1;
              spd_done_nxt = 1'b1;
            end else begin
              spd_cnt_nxt = spd_cnt_r + 4'd1;
            end
          end
        end
        OP_RAIN: begin
          if (!rain_seen_r || rain_last_r != q_op.level) begin
            rain_last_nxt = q_op.level;
            rain_seen_nxt = 1'b1;
            rain_cnt_nxt  = 4'd0;
            rain_done_nxt = 1'b0;
          end else if (!rain_done_r) begin
            if (rain_cnt_r >= RAIN_TICKS) begin
              rrep_nxt = 1'b1;
              if (rain_last_r) begin
                rain_flag_nxt = 1'b0;
              end else begin
                rain_flag_nxt = 1'b1;
                dr            = drive_f(pos_r, mot_r, lim_r, DRV_CLOSE);
                pos_nxt       = dr.pos;
                mot_nxt       = dr.mot;
                srep_nxt      = 1'b1;
              end
              rain_done_nxt = 1'b1;
            end else begin
              rain_cnt_nxt = rain_cnt_r + 4'd1;
            end
          end
        end
        OP_LIGHT: begin
          light_nxt = q_op.pct;
          if (cfg.smart_enable) begin
            if (9'(q_op.pct) > 9'(cfg.light_threshold) + CLOSE_OFFSET) begin
              dr = drive_f(pos_r, mot_r, lim_r, DRV_CLOSE);
            end else if (9'(q_op.pct) < 9'(cfg.light_threshold) + OPEN_OFFSET) begin
              dr = drive_f(pos_r, mot_r, lim_r, DRV_OPEN);
            end
            pos_nxt = dr.pos;
            mot_nxt = dr.mot;
          end
        end
        OP_CMD: begin
          dr       = drive_f(pos_r, mot_r, lim_r, q_op.drv);
          pos_nxt  = dr.pos;
          mot_nxt  = dr.mot;
          srep_nxt = 1'b1;
        end
        OP_KEY: begin
          case (pos_r) inside
            POS_STOPPED, POS_CLOSE_PAUSED, POS_FULLY_CLOSED:
              dr = drive_f(pos_r, mot_r, lim_r, DRV_OPEN);
            POS_OPENING, POS_CLOSING:
              dr = drive_f(pos_r, mot_r, lim_r, DRV_STOP);
            default:
              dr = drive_f(pos_r, mot_r, lim_r, DRV_CLOSE);
          endcase
          pos_nxt  = dr.pos;
          mot_nxt  = dr.mot;
          srep_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Assemble the result beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (q_pop) begin
      out_valid_nxt           = 1'b1;
      res_nxt.position_status = pos_nxt;
      res_nxt.motor_drive     = mot_nxt;
      res_nxt.end_limit       = lim_nxt;
      res_nxt.rain_alarm      = rain_flag_nxt;
      res_nxt.light_percent   = light_nxt;
      res_nxt.status_report   = srep_nxt;
      res_nxt.rain_report     = rrep_nxt;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_STOPPED;
      mot_r       <= MOT_OFF;
      lim_r       <= LIM_NONE;
      spd_last_r  <= 1'b0;
      spd_seen_r  <= 1'b0;
      spd_cnt_r   <= 4'd0;
      spd_done_r  <= 1'b0;
      rain_last_r <= 1'b0;
      rain_seen_r <= 1'b0;
      rain_cnt_r  <= 4'd0;
      rain_done_r <= 1'b0;
      rain_flag_r <= 1'b0;
      light_r     <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      mot_r       <= mot_nxt;
      lim_r       <= lim_nxt;
      spd_last_r  <= spd_last_nxt;
      spd_seen_r  <= spd_seen_nxt;
      spd_cnt_r   <= spd_cnt_nxt;
      spd_done_r  <= spd_done_nxt;
      rain_last_r <= rain_last_nxt;
      rain_seen_r <= rain_seen_nxt;
      rain_cnt_r  <= rain_cnt_nxt;
      rain_done_r <= rain_done_nxt;
      rain_flag_r <= rain_flag_nxt;
      light_r     <= light_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_fwd_iff_opening: assert property (@(posedge clk) disable iff (!rst_n)
    (mot_r == MOT_FWD) == (pos_r == POS_OPENING))
    else $error("forward drive out of step with opening status");
  a_rev_iff_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (mot_r == MOT_REV) == (pos_r == POS_CLOSING))
    else $error("reverse drive out of step with closing status");
  a_open_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (lim_r == LIM_OPEN) |-> (mot_r != MOT_FWD))
    else $error("forward drive at open-side end");
  a_rain_rep_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.rain_report) |-> rain_done_r)
    else $error("rain report without finished debounce");

endmodule

### rtl/curtain_motor_controller.sv
// Top level of the curtain motor controller: ports, registers and wiring.
`timescale 1ns / 1ps
// Curtain motor controller.
// Input beats on in_* carry one event each: in_tuser is the event kind
// (speed tick, rain tick, light sample, command, key press) and in_tdata
// holds the sensor levels, the light sample and the command byte.
// Every accepted input beat yields exactly one result beat on out_*, with
// position status, motor drive, end limit, rain alarm, light percent and
// the report flags.
// The front end decodes the beat and scales the light sample, a two-entry
// queue decouples it from the back end, which updates the controller state
// and loads the result register.
// Each accepted beat is written into the queue, popped by the back end and
// loaded into the result register, which drives out_tvalid and out_tdata.
// Throughput is one beat per cycle while the receiver holds out_tready high.
// When the receiver stalls, the result register holds, the queue fills to its
// two entries and in_tready drops; no beat is lost.
// Synchronous reset clears the control state and both registers to zero (not the
// queue entries or result payload); the block accepts beats once reset is released.
// The APB port writes smart_enable at 0x0 and light_threshold at 0x4.
module curtain_motor_controller (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] speed_level, [1] rain_level, [9:2] light_sample,
  // [17:10] command, [23:18] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // in_tuser: [2:0] kind
  input  logic [2:0]  in_tuser,
  // out_tdata: [2:0] position_status, [4:3] motor_drive, [6:5] end_limit,
  // [7] rain_alarm, [14:8] light_percent, [15] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // out_tuser: [0] status_report, [1] rain_report
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cmc_pkg::*;

  logic       smart_r;
  logic [7:0] thr_r;
  logic       cfg_wr;
  cfg_t       cfg;
  op_t        fe_op;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  op_t        q_op;
  res_t       res;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smart_r <= 1'b0;
      thr_r   <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SMART:     smart_r <= cfg_pwdata[0];
        REG_THRESHOLD: thr_r   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_paddr[2])
      REG_SMART:     cfg_prdata = {31'd0, smart_r};
      REG_THRESHOLD: cfg_prdata = {24'd0, thr_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.smart_enable    = smart_r;
  assign cfg.light_threshold = thr_r;

  // Front end
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  cmc_front u_front (
    .kind         (in_tuser),
    .speed_level  (in_tdata[0]),
    .rain_level   (in_tdata[1]),
    .light_sample (in_tdata[9:2]),
    .command      (in_tdata[17:10]),
    .op           (fe_op)
  );

  cmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (fe_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_op)
  );

  // Back end
  cmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {1'b0, res.light_percent, res.rain_alarm, res.end_limit,
                      res.motor_drive, res.position_status};
  assign out_tuser = {res.rain_report, res.status_report};

endmodule

### tb/sv/curtain_motor_controller_test.sv
// Testbench for the curtain motor controller: predicted result beats checked field by field.
`timescale 1ns / 1ps
module curtain_motor_controller_test;
  import cmc_pkg::*;

  localparam logic [7:0] CMD_STOP    = 8'd0;
  localparam int         QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Controller image kept by the predictor
  logic       smart_m    = 1'b0;
  logic [7:0] thresh_m   = 8'd0;
  pos_t       pos_m      = POS_STOPPED;
  motor_t     mot_m      = MOT_OFF;
  limit_t     lim_m      = LIM_NONE;
  logic       spd_last_m = 1'b0;
  logic       spd_seen_m = 1'b0;
  logic       spd_done_m = 1'b0;
  logic [3:0] spd_cnt_m  = 4'd0;
  logic       rain_last_m = 1'b0;
  logic       rain_seen_m = 1'b0;
  logic       rain_done_m = 1'b0;
  logic [3:0] rain_cnt_m  = 4'd0;
  logic       alarm_m    = 1'b0;
  logic [6:0] pct_m      = 7'd0;

  res_t reports_due[$];
  int   fail_count      = 0;
  int   items_sent      = 0;
  int   quiet_cycles    = 0;
  int   hold_off_cycles = 0;
  bit   in_idle_on      = 1'b1;
  bit   out_idle_on     = 1'b1;

  curtain_motor_controller u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply an open, close or stop request to the position and motor image
  function automatic void apply_drive(input logic [7:0] req);
    if (req == CMD_OPEN) begin
      if (pos_m != POS_FULLY_OPEN && lim_m != LIM_OPEN) begin
        pos_m = POS_OPENING;
        mot_m = MOT_FWD;
      end
    end else if (req == CMD_CLOSE) begin
      if (pos_m != POS_FULLY_CLOSED && lim_m != LIM_CLOSE) begin
        pos_m = POS_CLOSING;
        mot_m = MOT_REV;
      end
    end else begin
      if (lim_m == LIM_OPEN) pos_m = POS_FULLY_OPEN;
      else if (lim_m == LIM_CLOSE) pos_m = POS_FULLY_CLOSED;
      else if (pos_m == POS_OPENING) pos_m = POS_OPEN_PAUSED;
      else if (pos_m == POS_CLOSING) pos_m = POS_CLOSE_PAUSED;
      mot_m = MOT_OFF;
    end
  endfunction

  // Advance the controller image by one event and return the status it reports
  function automatic res_t step_curtain(input logic [2:0] kind, input logic spd,
                                        input logic rain, input logic [7:0] sample,
                                        input logic [7:0] cmd);
    res_t r;
    logic status_rep;
    logic rain_rep;
    int   pct;
    status_rep = 1'b0;
    rain_rep   = 1'b0;
    case (kind)
      KIND_SPEED: begin
        if (!spd_seen_m || spd_last_m != spd) begin
          spd_last_m = spd;
          spd_seen_m = 1'b1;
          spd_cnt_m  = 4'd0;
          spd_done_m = 1'b0;
          lim_m      = LIM_NONE;
        end else if (!spd_done_m) begin
          if (spd_cnt_m >= STALL_TICKS) begin
            // stalled: an end stop only while moving
            if (pos_m == POS_OPENING) begin
              lim_m = LIM_OPEN;
              apply_drive(CMD_STOP);
            end else if (pos_m == POS_CLOSING) begin
              lim_m = LIM_CLOSE;
              apply_drive(CMD_STOP);
            end
            status_rep = 1'b1;
            spd_done_m = 1'b1;
          end else begin
            spd_cnt_m = spd_cnt_m + 4'd1;
          end
        end
      end
      KIND_RAIN: begin
        if (!rain_seen_m || rain_last_m != rain) begin
          rain_last_m = rain;
          rain_seen_m = 1'b1;
          rain_cnt_m  = 4'd0;
          rain_done_m = 1'b0;
        end else if (!rain_done_m) begin
          if (rain_cnt_m >= RAIN_TICKS) begin
            rain_rep = 1'b1;
            if (rain_last_m) begin
              alarm_m = 1'b0;
            end else begin
              alarm_m = 1'b1;
              apply_drive(CMD_CLOSE);
              status_rep = 1'b1;
            end
            rain_done_m = 1'b1;
          end else begin
            rain_cnt_m = rain_cnt_m + 4'd1;
          end
        end
      end
      KIND_LIGHT: begin
        pct   = (int'(sample) * 100) / 255;
        pct_m = pct[6:0];
        if (smart_m) begin
          if (pct > int'(thresh_m) + int'(CLOSE_OFFSET)) apply_drive(CMD_CLOSE);
          else if (pct < int'(thresh_m) + int'(OPEN_OFFSET)) apply_drive(CMD_OPEN);
        end
      end
      KIND_CMD: begin
        apply_drive(cmd);
        status_rep = 1'b1;
      end
      KIND_KEY: begin
        case (pos_m)
          POS_STOPPED, POS_CLOSE_PAUSED, POS_FULLY_CLOSED: apply_drive(CMD_OPEN);
          POS_OPENING, POS_CLOSING: apply_drive(CMD_STOP);
          default: apply_drive(CMD_CLOSE);
        endcase
        status_rep = 1'b1;
      end
      default: ;
    endcase
    r.position_status = pos_m;
    r.motor_drive     = mot_m;
    r.end_limit       = lim_m;
    r.rain_alarm      = alarm_m;
    r.light_percent   = pct_m;
    r.status_report   = status_rep;
    r.rain_report     = rain_rep;
    return r;
  endfunction

  // Send one event beat; fields the kind does not use carry random bits
  task automatic send_event(input int kind, input int value);
    logic [31:0] noise;
    logic [2:0]  k;
    logic        spd;
    logic        rain;
    logic [7:0]  sample;
    logic [7:0]  cmd;
    noise  = $urandom();
    k      = kind[2:0];
    spd    = noise[0];
    rain   = noise[1];
    sample = noise[9:2];
    cmd    = noise[17:10];
    case (k)
      KIND_SPEED: spd = value[0];
      KIND_RAIN:  rain = value[0];
      KIND_LIGHT: sample = value[7:0];
      KIND_CMD:   cmd = value[7:0];
      default: ;
    endcase
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {6'd0, cmd, sample, rain, spd};
    do @(posedge clk); while (!in_tready);
    reports_due.push_back(step_curtain(k, spd, rain, sample, cmd));
    items_sent++;
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup beat, then access beat; upper bits carry noise
  task automatic write_reg(input logic idx, input logic [7:0] value);
    logic [31:0] wdata;
    wdata = $urandom();
    if (idx == REG_SMART) wdata[0] = value[0];
    else wdata[7:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_SMART) smart_m = wdata[0];
    else thresh_m = wdata[7:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    // Read the register back: setup beat, then access beat
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_SMART) check_field("smart_enable", int'(smart_m), int'(cfg_prdata));
    else check_field("light_threshold", int'(thresh_m), int'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the speed level for a run of ticks, mostly after a level change
  task automatic hold_speed(input int ticks);
    logic lvl;
    lvl = ($urandom_range(0, 3) == 0) ? spd_last_m : !spd_last_m;
    repeat (ticks) begin
      if ($urandom_range(0, 11) == 0) send_event(KIND_RAIN, $urandom_range(0, 1));
      send_event(KIND_SPEED, lvl);
    end
  endtask

  // Hold the rain level for a run of ticks, mostly after a level change
  task automatic hold_rain(input int ticks);
    logic lvl;
    lvl = ($urandom_range(0, 3) == 0) ? rain_last_m : !rain_last_m;
    repeat (ticks) begin
      if ($urandom_range(0, 11) == 0) send_event(KIND_SPEED, $urandom_range(0, 1));
      send_event(KIND_RAIN, lvl);
    end
  endtask

  // One event of any kind, spare kinds included
  task automatic send_any();
    int kind;
    int value;
    if ($urandom_range(0, 9) == 0) kind = $urandom_range(KIND_KEY + 1, 7);
    else kind = $urandom_range(0, KIND_KEY);
    value = $urandom_range(0, 255);
    if (kind == KIND_CMD && $urandom_range(0, 2) != 0)
      value = ($urandom_range(0, 1) == 0) ? CMD_OPEN : CMD_CLOSE;
    send_event(kind, value);
  endtask

  // A stall or rain run now and then, mostly single events
  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      send_event(KIND_CMD, ($urandom_range(0, 1) == 0) ? CMD_OPEN : CMD_CLOSE);
      hold_speed($urandom_range(10, 18));
    end else if (pick < 6) begin
      hold_rain($urandom_range(6, 13));
    end else begin
      send_any();
    end
  endtask

  task automatic test_directed_basics();
    int k;
    write_reg(REG_SMART, 8'd0);
    write_reg(REG_THRESHOLD, 8'd255);
    // first samples after reset count as level changes
    send_event(KIND_SPEED, 0);
    send_event(KIND_RAIN, 1);
    send_event(KIND_CMD, CMD_OPEN);
    send_event(KIND_CMD, 8'hFF);
    send_event(KIND_CMD, CMD_CLOSE);
    send_event(KIND_CMD, CMD_STOP);
    // walk the key through open, stop and close
    repeat (4) send_event(KIND_KEY, 0);
    send_event(KIND_LIGHT, 0);
    send_event(KIND_LIGHT, 255);
    send_event(KIND_LIGHT, 128);
    for (k = KIND_KEY + 1; k < 8; k++) send_event(k, 255);
    send_event(KIND_SPEED, 1);
    send_event(KIND_RAIN, 0);
  endtask

  task automatic test_stall_stops();
    int run;
    for (run = 0; run < 18; run++) begin
      case ($urandom_range(0, 4))
        0: send_event(KIND_CMD, CMD_OPEN);
        1: send_event(KIND_CMD, CMD_CLOSE);
        2: send_event(KIND_KEY, 0);
        3: send_event(KIND_CMD, CMD_STOP);
        default: ;
      endcase
      hold_speed($urandom_range(12, 20));
      // push toward the end just reached; blocked commands still report
      send_event(KIND_CMD, (lim_m == LIM_OPEN) ? CMD_OPEN : CMD_CLOSE);
    end
  endtask

  task automatic test_rain_alarm();
    int run;
    for (run = 0; run < 14; run++) begin
      if ($urandom_range(0, 1) == 0) send_event(KIND_CMD, CMD_OPEN);
      hold_rain($urandom_range(8, 14));
    end
  endtask

  task automatic test_smart_light();
    int phase;
    int pick;
    int goal;
    int base;
    for (phase = 0; phase < 5; phase++) begin
      settle_block();
      write_reg(REG_SMART, (phase == 3) ? 8'd0 : 8'd1);
      base = $urandom_range(0, 90);
      if (phase == 0) base = 0;
      else if (phase == 1) base = 255;
      write_reg(REG_THRESHOLD, base[7:0]);
      repeat (50) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // aim at the hysteresis band half of the time
          goal = int'(thresh_m) + $urandom_range(5, 25);
          if (goal > 100) goal = 100;
          if (pick < 3) send_event(KIND_LIGHT, (goal * 255 + 99) / 100);
          else send_event(KIND_LIGHT, $urandom_range(0, 255));
        end else if (pick < 8) begin
          send_any();
        end else begin
          send_event(KIND_SPEED, $urandom_range(0, 1));
        end
      end
    end
  endtask

  task automatic test_input_backpressure();
    in_idle_on      = 1'b0;
    hold_off_cycles = 64;
    repeat (30) send_any();
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    logic [31:0] regs;
    int          stop_at;
    while (items_sent < 1060) begin
      settle_block();
      regs = $urandom();
      write_reg(REG_SMART, regs[7:0]);
      write_reg(REG_THRESHOLD, regs[15:8]);
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      stop_at = items_sent + 120;
      while (items_sent < stop_at) random_step();
    end
  endtask

  task automatic test_steady_tail();
    int stop_at;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    stop_at = items_sent + 120;
    while (items_sent < stop_at) random_step();
  endtask

  initial begin : run_tests
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_stall_stops();
    test_rain_alarm();
    test_smart_light();
    test_input_backpressure();
    test_random_mix();
    test_steady_tail();
    settle_block();
    if (fail_count == 0) begin
      $display("** curtain_motor_controller: PASSED **");
    end else begin
      $display("** curtain_motor_controller: FAILED **");
    end
    $finish;
  end

  // Result side ready: long hold-off on request, else random stall bursts
  initial begin : result_sink
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_tready <= 1'b1;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (out_tvalid && out_tready) begin
      if (reports_due.size() == 0) begin
        $error("result beat with no prediction pending");
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("position_status", want.position_status, out_tdata[2:0]);
        check_field("motor_drive", want.motor_drive, out_tdata[4:3]);
        check_field("end_limit", want.end_limit, out_tdata[6:5]);
        check_field("rain_alarm", want.rain_alarm, out_tdata[7]);
        check_field("light_percent", want.light_percent, out_tdata[14:8]);
        check_field("status_report", want.status_report, out_tuser[0]);
        check_field("rain_report", want.rain_report, out_tuser[1]);
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** curtain_motor_controller: FAILED **");
        $finish;
      end
    end
  end

endmodule

### curtain_motor_controller.f
rtl/cmc_pkg.sv
rtl/cmc_front.sv
rtl/cmc_queue.sv
rtl/cmc_back.sv
rtl/curtain_motor_controller.sv
tb/sv/curtain_motor_controller_test.sv
